FILE: rtl/arp_cache_with_aging_macros.svh
// assertion macros used by the arp cache checker
`ifndef ARP_CACHE_WITH_AGING_MACROS_SVH
`define ARP_CACHE_WITH_AGING_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define ARPC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arp cache check failed");

// next-cycle implication
`define ARPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arp cache check failed");

`endif

FILE: rtl/arpc_pkg.sv
package arpc_pkg;

    localparam int CACHE_ENTRIES = 8;
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int LIFE_W    = 7;
    localparam int STATUS_W  = 4;
    localparam int IDX_OUT_W = 3;
    localparam int CNT_OUT_W = 4;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_LEARN  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_HIT      = 4'd0;
    localparam logic [STATUS_W-1:0] STAT_BCAST    = 4'd1;
    localparam logic [STATUS_W-1:0] STAT_MCAST    = 4'd2;
    localparam logic [STATUS_W-1:0] STAT_MISS     = 4'd3;
    localparam logic [STATUS_W-1:0] STAT_REFRESH  = 4'd4;
    localparam logic [STATUS_W-1:0] STAT_ADDED    = 4'd5;
    localparam logic [STATUS_W-1:0] STAT_REPLACED = 4'd6;
    localparam logic [STATUS_W-1:0] STAT_IGNORED  = 4'd7;
    localparam logic [STATUS_W-1:0] STAT_TICK     = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_IP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_IP       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_IP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_MAC = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MCAST_ENABLE  = 3'd7;

    // fixed multicast name groups
    localparam logic [IP_W-1:0]  MDNS_IP         = 32'hE000_00FB;
    localparam logic [IP_W-1:0]  LLMNR_IP        = 32'hE000_00FC;
    localparam logic [MAC_W-1:0] MDNS_GROUP_MAC  = 48'h0100_5E00_00FB;
    localparam logic [MAC_W-1:0] LLMNR_GROUP_MAC = 48'h0100_5E00_00FC;

    localparam logic [LIFE_W-1:0] HOLD_TICKS_RST = 7'd100;

    typedef struct packed {
        logic [IP_W-1:0]   own_ip;
        logic [IP_W-1:0]   subnet_mask;
        logic [IP_W-1:0]   gateway_ip;
        logic [LIFE_W-1:0] hold_ticks;
        logic [IP_W-1:0]   null_ip;
        logic [IP_W-1:0]   broadcast_ip;
        logic [MAC_W-1:0]  broadcast_mac;
        logic              mcast_en;
    } cfg_t;

    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [LIFE_W-1:0] life;
    } entry_t;

endpackage

FILE: rtl/arpc_cfg.sv
module arpc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data,
    output arpc_pkg::cfg_t                 cfg
);
    import arpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OWN_IP:        cfg_next.own_ip        = cfg_data[IP_W-1:0];
                CFG_SUBNET_MASK:   cfg_next.subnet_mask   = cfg_data[IP_W-1:0];
                CFG_GATEWAY_IP:    cfg_next.gateway_ip    = cfg_data[IP_W-1:0];
                CFG_HOLD_TICKS:    cfg_next.hold_ticks    = cfg_data[LIFE_W-1:0];
                CFG_NULL_IP:       cfg_next.null_ip       = cfg_data[IP_W-1:0];
                CFG_BROADCAST_IP:  cfg_next.broadcast_ip  = cfg_data[IP_W-1:0];
                CFG_BROADCAST_MAC: cfg_next.broadcast_mac = cfg_data[MAC_W-1:0];
                CFG_MCAST_ENABLE:  cfg_next.mcast_en      = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_ip        <= '0;
            cfg_reg.subnet_mask   <= '0;
            cfg_reg.gateway_ip    <= '0;
            cfg_reg.hold_ticks    <= HOLD_TICKS_RST;
            cfg_reg.null_ip       <= '0;
            cfg_reg.broadcast_ip  <= '1;
            cfg_reg.broadcast_mac <= '1;
            cfg_reg.mcast_en      <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/arp_cache_with_aging.sv
// ip-to-mac cache with aging. one request in, one result out. entries live in a small
// synchronous memory with one read and one write port; learn, lookup and tick walk the
// valid entries one per cycle through that read port. requests that resolve without the
// walk (ignored learn, multicast, broadcast, null, unused type, gateway that is null or
// broadcast) go straight to the finishing step. the next request can be taken in the
// same cycle as the last result appears. a finished result sits in the output register
// so the next request can be accepted while it waits; the finishing step of that next
// request waits until it is taken.
module arp_cache_with_aging (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [arpc_pkg::REQ_W-1:0]      req_type,
    input  logic [arpc_pkg::IP_W-1:0]       ip_addr,
    input  logic [arpc_pkg::MAC_W-1:0]      mac_addr,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [arpc_pkg::STATUS_W-1:0]   status,
    output logic [arpc_pkg::MAC_W-1:0]      mac_result,
    output logic [arpc_pkg::IP_W-1:0]       ask_ip,
    output logic [arpc_pkg::IDX_OUT_W-1:0]  entry_index,
    output logic [arpc_pkg::CNT_OUT_W-1:0]  entry_count,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import arpc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        OP_LEARN  = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_TICK   = 2'd2,
        OP_IMM    = 2'd3
    } op_t;

    cfg_t cfg;

    arpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // entry memory
    entry_t             mem [CACHE_ENTRIES];
    entry_t             rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [IDX_W-1:0]   cmp_ptr_reg, cmp_ptr_next;
    logic               pv_reg, pv_next;
    logic [CNT_W-1:0]   wp_reg, wp_next;
    logic [IP_W-1:0]    key_reg, key_next;
    logic [MAC_W-1:0]   mac_in_reg, mac_in_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [MAC_W-1:0]   hit_mac_reg, hit_mac_next;
    logic [IDX_W-1:0]   min_idx_reg, min_idx_next;
    logic [LIFE_W-1:0]  min_life_reg, min_life_next;
    logic [STATUS_W-1:0] imm_status_reg, imm_status_next;
    logic [MAC_W-1:0]   imm_mac_reg, imm_mac_next;
    logic [IP_W-1:0]    imm_ask_reg, imm_ask_next;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [MAC_W-1:0]     mac_result_reg, mac_result_next;
    logic [IP_W-1:0]      ask_ip_reg, ask_ip_next;
    logic [IDX_W-1:0]     index_reg, index_next;
    logic [CNT_W-1:0]     ecount_reg, ecount_next;

    logic               in_fire;
    logic               out_free;
    logic               issue;
    logic               in_nb;
    logic               is_local;
    logic [IP_W-1:0]    tgt_ip;
    logic               tgt_nb;
    logic               full;
    logic [STATUS_W-1:0] fin_status;
    logic [MAC_W-1:0]   fin_mac;
    logic [IP_W-1:0]    fin_ask;
    logic [IDX_W-1:0]   fin_idx;
    logic [CNT_W-1:0]   fin_count;
    logic               fin_wr;
    logic [IDX_W-1:0]   fin_wr_addr;
    entry_t             fin_wr_data;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign issue     = (state_reg == S_SCAN) && (rd_ptr_reg < count_reg);
    assign rd_addr   = rd_ptr_reg[IDX_W-1:0];
    assign full      = (count_reg == CNT_W'(CACHE_ENTRIES));

    assign in_nb    = (ip_addr == cfg.null_ip) || (ip_addr == cfg.broadcast_ip);
    assign is_local = ((ip_addr & cfg.subnet_mask) == (cfg.own_ip & cfg.subnet_mask));
    assign tgt_ip   = is_local ? ip_addr : cfg.gateway_ip;
    assign tgt_nb   = (tgt_ip == cfg.null_ip) || (tgt_ip == cfg.broadcast_ip);

    // result and write-back of the finishing step
    always_comb
    begin
        fin_status  = STAT_IGNORED;
        fin_mac     = '0;
        fin_ask     = '0;
        fin_idx     = '0;
        fin_count   = count_reg;
        fin_wr      = 1'b0;
        fin_wr_addr = hit_idx_reg;
        fin_wr_data = '{ip: key_reg, mac: mac_in_reg, life: cfg.hold_ticks};
        case (op_reg)
            OP_LEARN:
            begin
                fin_wr = 1'b1;
                if (hit_reg)
                begin
                    fin_status      = STAT_REFRESH;
                    fin_idx         = hit_idx_reg;
                    fin_wr_data.mac = hit_mac_reg;
                end
                else if (!full)
                begin
                    fin_status  = STAT_ADDED;
                    fin_idx     = count_reg[IDX_W-1:0];
                    fin_wr_addr = count_reg[IDX_W-1:0];
                    fin_count   = count_reg + 1'b1;
                end
                else
                begin
                    fin_status  = STAT_REPLACED;
                    fin_idx     = min_idx_reg;
                    fin_wr_addr = min_idx_reg;
                end
            end
            OP_LOOKUP:
            begin
                if (hit_reg)
                begin
                    fin_status = STAT_HIT;
                    fin_mac    = hit_mac_reg;
                    fin_idx    = hit_idx_reg;
                end
                else
                begin
                    fin_status = STAT_MISS;
                    fin_ask    = key_reg;
                end
            end
            OP_TICK:
            begin
                fin_status = STAT_TICK;
                fin_count  = wp_reg;
            end
            default:
            begin
                fin_status = imm_status_reg;
                fin_mac    = imm_mac_reg;
                fin_ask    = imm_ask_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        cmp_ptr_next    = cmp_ptr_reg;
        pv_next         = 1'b0;
        wp_next         = wp_reg;
        key_next        = key_reg;
        mac_in_next     = mac_in_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_mac_next    = hit_mac_reg;
        min_idx_next    = min_idx_reg;
        min_life_next   = min_life_reg;
        imm_status_next = imm_status_reg;
        imm_mac_next    = imm_mac_reg;
        imm_ask_next    = imm_ask_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        mac_result_next = mac_result_reg;
        ask_ip_next     = ask_ip_reg;
        index_next      = index_reg;
        ecount_next     = ecount_reg;
        wr_en           = 1'b0;
        wr_addr         = wp_reg[IDX_W-1:0];
        wr_data         = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    rd_ptr_next     = '0;
                    wp_next         = '0;
                    hit_next        = 1'b0;
                    hit_idx_next    = '0;
                    min_idx_next    = '0;
                    key_next        = ip_addr;
                    mac_in_next     = mac_addr;
                    imm_status_next = STAT_IGNORED;
                    imm_mac_next    = '0;
                    imm_ask_next    = '0;
                    op_next         = OP_IMM;
                    state_next      = S_FIN;
                    case (req_type)
                        REQ_LEARN:
                        begin
                            if (!in_nb)
                            begin
                                op_next    = OP_LEARN;
                                state_next = S_SCAN;
                            end
                        end
                        REQ_LOOKUP:
                        begin
                            if (cfg.mcast_en && ip_addr == LLMNR_IP)
                            begin
                                imm_status_next = STAT_MCAST;
                                imm_mac_next    = LLMNR_GROUP_MAC;
                            end
                            else if (cfg.mcast_en && ip_addr == MDNS_IP)
                            begin
                                imm_status_next = STAT_MCAST;
                                imm_mac_next    = MDNS_GROUP_MAC;
                            end
                            else if (in_nb)
                            begin
                                imm_status_next = STAT_BCAST;
                                imm_mac_next    = cfg.broadcast_mac;
                            end
                            else if (tgt_nb)
                            begin
                                // gateway is null or broadcast: never held
                                imm_status_next = STAT_MISS;
                                imm_ask_next    = tgt_ip;
                            end
                            else
                            begin
                                key_next   = tgt_ip;
                                op_next    = OP_LOOKUP;
                                state_next = S_SCAN;
                            end
                        end
                        REQ_TICK:
                        begin
                            op_next    = OP_TICK;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            op_next = OP_IMM;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    pv_next      = 1'b1;
                    cmp_ptr_next = rd_ptr_reg[IDX_W-1:0];
                    rd_ptr_next  = rd_ptr_reg + 1'b1;
                end
                if (pv_reg)
                begin
                    if (!hit_reg && rd_data_reg.ip == key_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_ptr_reg;
                        hit_mac_next = rd_data_reg.mac;
                    end
                    // first lowest lifetime wins a tie
                    if (cmp_ptr_reg == '0 || rd_data_reg.life < min_life_reg)
                    begin
                        min_idx_next  = cmp_ptr_reg;
                        min_life_next = rd_data_reg.life;
                    end
                    // aging: survivors are compacted down to the write pointer
                    if (op_reg == OP_TICK && rd_data_reg.life != '0)
                    begin
                        wr_en        = 1'b1;
                        wr_addr      = wp_reg[IDX_W-1:0];
                        wr_data.life = rd_data_reg.life - 1'b1;
                        wp_next      = wp_reg + 1'b1;
                    end
                end
                if (!issue && !pv_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    wr_en           = fin_wr;
                    wr_addr         = fin_wr_addr;
                    wr_data         = fin_wr_data;
                    count_next      = fin_count;
                    out_valid_next  = 1'b1;
                    status_next     = fin_status;
                    mac_result_next = fin_mac;
                    ask_ip_next     = fin_ask;
                    index_next      = fin_idx;
                    ecount_next     = fin_count;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_IMM;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            pv_reg        <= 1'b0;
            wp_reg        <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            pv_reg        <= pv_next;
            wp_reg        <= wp_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_ptr_reg    <= cmp_ptr_next;
        key_reg        <= key_next;
        mac_in_reg     <= mac_in_next;
        hit_idx_reg    <= hit_idx_next;
        hit_mac_reg    <= hit_mac_next;
        min_idx_reg    <= min_idx_next;
        min_life_reg   <= min_life_next;
        imm_status_reg <= imm_status_next;
        imm_mac_reg    <= imm_mac_next;
        imm_ask_reg    <= imm_ask_next;
        status_reg     <= status_next;
        mac_result_reg <= mac_result_next;
        ask_ip_reg     <= ask_ip_next;
        index_reg      <= index_next;
        ecount_reg     <= ecount_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign mac_result  = mac_result_reg;
    assign ask_ip      = ask_ip_reg;
    assign entry_index = IDX_OUT_W'(index_reg);
    assign entry_count = CNT_OUT_W'(ecount_reg);

endmodule

FILE: rtl/arpc_checker.sv
`include "arp_cache_with_aging_macros.svh"

module arpc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [arpc_pkg::STATUS_W-1:0]   status,
    input logic [arpc_pkg::MAC_W-1:0]      mac_result,
    input logic [arpc_pkg::IP_W-1:0]       ask_ip,
    input logic [arpc_pkg::IDX_OUT_W-1:0]  entry_index,
    input logic [arpc_pkg::CNT_OUT_W-1:0]  entry_count
);
    import arpc_pkg::*;

    logic                                                out_stall;
    logic                                                idx_reported;
    logic [STATUS_W+MAC_W+IP_W+IDX_OUT_W+CNT_OUT_W-1:0] res_bits;

    assign out_stall    = out_valid && !out_ready;
    assign idx_reported = out_valid &&
                          (status inside {STAT_HIT, STAT_REFRESH, STAT_ADDED, STAT_REPLACED});
    assign res_bits     = {status, mac_result, ask_ip, entry_index, entry_count};

    // one request in flight at a time
    `ARPC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

    // a stalled result holds
    `ARPC_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(res_bits))

    // an entry reported by index lies below the entry count
    `ARPC_ASSERT_NOW(a_idx_in_range, idx_reported, {1'b0, entry_index} < entry_count)

    // only a miss asks for an address
    `ARPC_ASSERT_NOW(a_ask_only_miss, out_valid && status != STAT_MISS, ask_ip == '0)

endmodule

bind arp_cache_with_aging arpc_checker u_arpc_checker (.*);
